/* rtl/brb_pkg.sv */
// ---------------------------------------------------------------------------
// brb_pkg
// Types and constants for the circular byte buffer.
// ---------------------------------------------------------------------------
package brb_pkg;

  localparam int CNT_W = 9;

  localparam logic [3:0] OP_CLEAR  = 4'd0;
  localparam logic [3:0] OP_PUSH8  = 4'd1;
  localparam logic [3:0] OP_PUSH16 = 4'd2;
  localparam logic [3:0] OP_PUSH32 = 4'd3;
  localparam logic [3:0] OP_READ8  = 4'd4;
  localparam logic [3:0] OP_READ32 = 4'd5;
  localparam logic [3:0] OP_POP8   = 4'd6;
  localparam logic [3:0] OP_POP32  = 4'd7;
  localparam logic [3:0] OP_REMOVE = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [3:0]       operation;
    logic [31:0]      value;
    logic [7:0]       offset;
    logic [CNT_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      data;
    logic [CNT_W-1:0] fill;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_RD,
    S_RDW,
    S_REM,
    S_SHRD,
    S_SHWR,
    S_FIN
  } state_t;

endpackage

/* rtl/brb_ram.sv */
// ---------------------------------------------------------------------------
// brb_ram
// Generic RAM, one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/brb_addr.sv */
// ---------------------------------------------------------------------------
// brb_addr
// Ring address unit: (base + index) mod capacity, for index below capacity.
// ---------------------------------------------------------------------------
module brb_addr #(
  parameter int AW = 8
) (
  input  logic [AW-1:0]             base,
  input  logic [brb_pkg::CNT_W-1:0] idx,
  input  logic [brb_pkg::CNT_W-1:0] cap,
  output logic [AW-1:0]             phys
);

  import brb_pkg::*;

  localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  logic [SW-1:0] sum;
  logic [SW-1:0] cap_x;
  logic [SW-1:0] wrapped;

  assign sum     = SW'(base) + SW'(idx);
  assign cap_x   = SW'(cap);
  assign wrapped = (sum >= cap_x) ? (sum - cap_x) : sum;
  assign phys    = wrapped[AW-1:0];

endmodule

/* rtl/byte_ring_buffer_with_removal.sv */
// ---------------------------------------------------------------------------
// byte_ring_buffer_with_removal
// Circular byte store with pushes, offset reads, pops and range removal.
// ---------------------------------------------------------------------------
// One word is taken at a time and gives one result word. A sequencer drives
// a single ring address adder and a one-read, one-write byte RAM. Each word
// is decoded and checked first; clear, failed or unknown ops and removals
// without moves then finish. A push writes its n bytes (n = 1, 2 or 4) one
// at a time; a read fetches its bytes one at a time, a pop then removes them;
// a removal from the middle moves each later byte through the RAM, a read
// and then a write per byte. The result sits in an output register so the
// next word can be taken while it waits. A capacity write made while idle
// empties the store; no clearing pass is needed.
// ---------------------------------------------------------------------------
module byte_ring_buffer_with_removal #(
  parameter int MAX_CAPACITY = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [brb_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  brb_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output brb_pkg::out_item_t        out_data
);

  import brb_pkg::*;

  localparam int AW      = $clog2(MAX_CAPACITY);
  localparam int RST_CAP = (MAX_CAPACITY < 256) ? MAX_CAPACITY : 256;

  state_t state, state_next;

  logic [3:0]       op;
  logic [31:0]      val;
  logic [7:0]       off;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    head;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] rn;
  logic [1:0]       left;
  logic [31:0]      rdat;
  logic [1:0]       status;

  logic [CNT_W-1:0] cap_next;
  logic [CNT_W-1:0] n_push;
  logic [CNT_W-1:0] n_rd;
  logic             push_fit;
  logic             rd_short;
  logic             rem_bad;
  logic             is_push;
  logic             is_read;
  logic             is_pop;
  logic [CNT_W:0]   rem_end;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W:0]   sh_end;
  logic             fin_go;

  logic [CNT_W-1:0] a_idx;
  logic [AW-1:0]    phys;
  logic             ram_we;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  brb_addr #(.AW(AW)) u_addr (
    .base (head),
    .idx  (a_idx),
    .cap  (cap),
    .phys (phys)
  );

  brb_ram #(.WIDTH(8), .DEPTH(MAX_CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (phys),
    .wdata (ram_wdata),
    .raddr (phys),
    .rdata (ram_rdata)
  );

  // decode and conditions
  always_comb begin
    is_push  = (op inside {OP_PUSH8, OP_PUSH16, OP_PUSH32});
    is_read  = (op inside {OP_READ8, OP_READ32, OP_POP8, OP_POP32});
    is_pop   = (op inside {OP_POP8, OP_POP32});
    n_push   = (op == OP_PUSH8) ? CNT_W'(1) : (op == OP_PUSH16) ? CNT_W'(2) : CNT_W'(4);
    n_rd     = (op inside {OP_READ8, OP_POP8}) ? CNT_W'(1) : CNT_W'(4);
    push_fit = ({1'b0, held} + {1'b0, n_push}) <= {1'b0, cap};
    rd_short = {1'b0, held} < ({2'b00, off} + {1'b0, n_rd});
    rem_bad  = {1'b0, off} >= held;
    rem_end  = {2'b00, off} + {1'b0, rn};
    idx_inc  = idx + CNT_W'(1);
    sh_end   = {1'b0, idx_inc} + {1'b0, rn};
    fin_go   = !out_valid || out_ready;
    if (cfg_wdata == '0) begin
      cap_next = CNT_W'(1);
    end else if (int'(cfg_wdata) > MAX_CAPACITY) begin
      cap_next = CNT_W'(MAX_CAPACITY);
    end else begin
      cap_next = cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (is_push) begin
          state_next = push_fit ? S_PUSH : S_FIN;
        end else if (is_read) begin
          state_next = rd_short ? S_FIN : S_RD;
        end else if (op == OP_REMOVE) begin
          state_next = rem_bad ? S_FIN : S_REM;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PUSH: begin
        if (left == 2'd0) state_next = S_FIN;
      end
      S_RD: state_next = S_RDW;
      S_RDW: begin
        if (left != 2'd0) begin
          state_next = S_RD;
        end else begin
          state_next = is_pop ? S_REM : S_FIN;
        end
      end
      S_REM: begin
        if (rn == '0 || rn >= held || off == '0 || rem_end >= {1'b0, held}) begin
          state_next = S_FIN;
        end else begin
          state_next = S_SHRD;
        end
      end
      S_SHRD: state_next = S_SHWR;
      S_SHWR: begin
        state_next = (sh_end < {1'b0, held}) ? S_SHRD : S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // address unit and RAM control
  always_comb begin
    a_idx     = idx;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    case (state)
      S_PUSH: begin
        a_idx  = held;
        ram_we = 1'b1;
        case (left)
          2'd0:    ram_wdata = val[7:0];
          2'd1:    ram_wdata = val[15:8];
          2'd2:    ram_wdata = val[23:16];
          default: ram_wdata = val[31:24];
        endcase
      end
      S_REM:  a_idx = rn;
      S_SHRD: a_idx = idx + rn;
      S_SHWR: begin
        a_idx  = idx;
        ram_we = 1'b1;
      end
      default: a_idx = idx;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      held      <= '0;
      cap       <= CNT_W'(RST_CAP);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      if (cfg_wen) begin
        cap  <= cap_next;
        head <= '0;
        held <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op  <= in_data.operation;
            val <= in_data.value;
            off <= in_data.offset;
            cnt <= in_data.count;
          end
        end
        S_EXEC: begin
          rdat   <= '0;
          idx    <= CNT_W'(off);
          if (op == OP_CLEAR) begin
            status <= ST_OK;
            head   <= '0;
            held   <= '0;
          end else if (is_push) begin
            status <= push_fit ? ST_OK : ST_SHORT;
            left   <= n_push[1:0] - 2'd1;
          end else if (is_read) begin
            status <= rd_short ? ST_SHORT : ST_OK;
            left   <= n_rd[1:0] - 2'd1;
            rn     <= n_rd;
          end else if (op == OP_REMOVE) begin
            status <= rem_bad ? ST_RANGE : ST_OK;
            rn     <= cnt;
          end else begin
            status <= ST_OK;
          end
        end
        S_PUSH: begin
          held <= held + CNT_W'(1);
          left <= left - 2'd1;
        end
        S_RDW: begin
          rdat <= {rdat[23:0], ram_rdata};
          idx  <= idx_inc;
          left <= left - 2'd1;
        end
        S_REM: begin
          idx <= CNT_W'(off);
          if (rn == '0) begin
            held <= held;
          end else if (rn >= held) begin
            head <= '0;
            held <= '0;
          end else if (off == '0) begin
            head <= phys;
            held <= held - rn;
          end else if (rem_end >= {1'b0, held}) begin
            held <= CNT_W'(off);
          end
        end
        S_SHWR: begin
          idx <= idx_inc;
          if (sh_end >= {1'b0, held}) held <= held - rn;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid       <= 1'b1;
            out_data.status <= status;
            out_data.data   <= rdat;
            out_data.fill   <= held;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
